// ===== hdl/wtps_pkg.sv =====
// wtps_pkg: shared types, constants and arithmetic helpers of the w-term phase screen
// used by every module of the block; depends on nothing
package wtps_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int OUT_BITS    = 16;
    localparam int IDX_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int SPAN_W      = 12;
    localparam int D_W         = 13;
    localparam int SQRT_STAGES = 32;
    localparam int OUT_SH      = 33 - OUT_BITS;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SIZE_X  = 3'd0;
    localparam logic [2:0] REG_SIZE_Y  = 3'd1;
    localparam logic [2:0] REG_STEP_L  = 3'd2;
    localparam logic [2:0] REG_STEP_M  = 3'd3;
    localparam logic [2:0] REG_W_VALUE = 3'd4;

    // 2*pi in Q3.29
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // floor(2^32 / c) for the series divisors
    localparam logic [31:0] RECIP_6     = 32'd715827882;
    localparam logic [31:0] RECIP_24    = 32'd178956970;
    localparam logic [31:0] RECIP_120   = 32'd35791394;
    localparam logic [31:0] RECIP_720   = 32'd5965232;
    localparam logic [31:0] RECIP_5040  = 32'd852176;
    localparam logic [31:0] RECIP_40320 = 32'd106522;

    localparam logic [15:0] DIV_6     = 16'd6;
    localparam logic [15:0] DIV_24    = 16'd24;
    localparam logic [15:0] DIV_120   = 16'd120;
    localparam logic [15:0] DIV_720   = 16'd720;
    localparam logic [15:0] DIV_5040  = 16'd5040;
    localparam logic [15:0] DIV_40320 = 16'd40320;

    typedef struct packed {
        logic [IDX_W-1:0] x_index;
        logic [IDX_W-1:0] y_index;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] real_part;
        logic signed [OUT_BITS-1:0] imag_part;
        logic                       in_disc;
    } out_word_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_y;
        logic [31:0]        step_l;
        logic [31:0]        step_m;
        logic signed [31:0] w_value;
    } cfg_t;

    // sideband that follows a word through the trig stages
    typedef struct packed {
        logic [1:0] quad;
        logic       neg;
        logic       outside;
    } side_t;

    // clamped size minus one
    function automatic logic [SPAN_W-1:0] span_of(input logic [SIZE_W-1:0] size);
        logic [SPAN_W-1:0] s;
        if (size == '0)
            s = '0;
        else if (size > SIZE_W'(MAX_DIM))
            s = SPAN_W'(MAX_DIM - 1);
        else
            s = SPAN_W'(size - SIZE_W'(1));
        return s;
    endfunction

    // |2*idx - span|
    function automatic logic [D_W-1:0] offset_of(input logic [IDX_W-1:0] idx,
                                                 input logic [SPAN_W-1:0] span);
        logic [D_W-1:0] tw;
        logic [D_W-1:0] sp;
        tw = {idx, 1'b0};
        sp = {1'b0, span};
        return (tw >= sp) ? (tw - sp) : (sp - tw);
    endfunction

    // Q0.32 product, truncated
    function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[63:32];
    endfunction

    // quotient estimate, low by at most one
    function automatic logic [31:0] div_est(input logic [31:0] x, input logic [31:0] recip);
        logic [63:0] p;
        p = x * recip;
        return p[63:32];
    endfunction

    // one correction step of the estimate
    function automatic logic [31:0] div_fix(input logic [31:0] x, input logic [31:0] q,
                                            input logic [15:0] c);
        logic [47:0] m;
        logic [32:0] rem;
        m   = q * c;
        rem = {1'b0, x} - m[32:0];
        return (rem >= {17'd0, c}) ? (q + 32'd1) : q;
    endfunction

    // round half up to the output format and saturate
    function automatic logic [OUT_BITS-1:0] to_out(input logic [32:0] v);
        logic [33:0] s;
        logic [33:0] q;
        s = {1'b0, v} + (34'd1 << (OUT_SH - 1));
        q = s >> OUT_SH;
        if (q > 34'((34'd1 << (OUT_BITS - 1)) - 34'd1))
            q = 34'((34'd1 << (OUT_BITS - 1)) - 34'd1);
        return q[OUT_BITS-1:0];
    endfunction

endpackage

// ===== hdl/wtps_dircos.sv =====
// wtps_dircos: direction cosine magnitudes, their squares and 1 - l^2 - m^2
// depends on wtps_pkg
module wtps_dircos (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  wtps_pkg::in_word_t pixel,
    input  wtps_pkg::cfg_t    cfg,
    output logic              t_valid,
    output logic [32:0]       t_value,
    output logic              outside
);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [wtps_pkg::D_W-1:0] dl_reg, dm_reg;
    logic [43:0]              al_reg, am_reg;
    logic [31:0]              sql_reg, sqm_reg;
    logic                     big3_reg;
    logic [32:0]              t_reg;
    logic                     out4_reg;

    logic [44:0] pl_next, pm_next;
    logic [63:0] ql_next, qm_next;
    logic [32:0] sum_next;

    // control: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // products and sum
    always_comb
    begin
        pl_next  = cfg.step_l * dl_reg;
        pm_next  = cfg.step_m * dm_reg;
        ql_next  = al_reg[31:0] * al_reg[31:0];
        qm_next  = am_reg[31:0] * am_reg[31:0];
        sum_next = {1'b0, sql_reg} + {1'b0, sqm_reg};
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        dl_reg   <= wtps_pkg::offset_of(pixel.x_index, wtps_pkg::span_of(cfg.size_x));
        dm_reg   <= wtps_pkg::offset_of(pixel.y_index, wtps_pkg::span_of(cfg.size_y));
        al_reg   <= pl_next[44:1];
        am_reg   <= pm_next[44:1];
        sql_reg  <= ql_next[63:32];
        sqm_reg  <= qm_next[63:32];
        big3_reg <= (al_reg[43:32] != '0) || (am_reg[43:32] != '0);
        out4_reg <= big3_reg || sum_next[32];
        t_reg    <= 33'h1_0000_0000 - sum_next;
    end

    assign t_valid = v4_reg;
    assign t_value = t_reg;
    assign outside = out4_reg;

endmodule

// ===== hdl/wtps_sqrt.sv =====
// wtps_sqrt: pipelined restoring square root, one result bit per stage
// depends on wtps_pkg
module wtps_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic [32:0] t_value,
    input  logic        outside,
    output logic        r_valid,
    output logic [31:0] root,
    output logic        full,
    output logic        r_outside
);

    localparam int N = wtps_pkg::SQRT_STAGES;

    logic        val_reg  [1:N];
    logic [33:0] rem_reg  [1:N];
    logic [31:0] root_reg [1:N];
    logic [31:0] rad_reg  [1:N];
    logic        full_reg [1:N];
    logic        out_reg  [1:N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic        val_in;
            logic [33:0] rem_in;
            logic [31:0] root_in;
            logic [31:0] rad_in;
            logic        full_in;
            logic        out_in;
            logic [35:0] rem_sh;
            logic [35:0] trial;
            logic [33:0] rem_next;
            logic [31:0] root_next;

            // stage input: from the ports or the previous stage
            if (g == 0)
            begin : g_first
                always_comb
                begin
                    val_in  = valid;
                    rem_in  = '0;
                    root_in = '0;
                    rad_in  = t_value[31:0];
                    full_in = t_value[32];
                    out_in  = outside;
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    val_in  = val_reg[g];
                    rem_in  = rem_reg[g];
                    root_in = root_reg[g];
                    rad_in  = rad_reg[g];
                    full_in = full_reg[g];
                    out_in  = out_reg[g];
                end
            end

            // one trial subtraction
            always_comb
            begin
                rem_sh = {rem_in, rad_in[31:30]};
                trial  = {2'b00, root_in, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = 34'(rem_sh - trial);
                    root_next = {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[33:0];
                    root_next = {root_in[30:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    val_reg[g+1] <= 1'b0;
                else
                    val_reg[g+1] <= val_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g+1]  <= rem_next;
                root_reg[g+1] <= root_next;
                rad_reg[g+1]  <= {rad_in[29:0], 2'b00};
                full_reg[g+1] <= full_in;
                out_reg[g+1]  <= out_in;
            end
        end
    endgenerate

    assign r_valid   = val_reg[N];
    assign root      = root_reg[N];
    assign full      = full_reg[N];
    assign r_outside = out_reg[N];

endmodule

// ===== hdl/wtps_phase.sv =====
// wtps_phase: w times (1 - n), wrap to turns, octant reduction and scaling to radians
// depends on wtps_pkg
module wtps_phase (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  logic [31:0]        root,
    input  logic               full,
    input  logic               outside,
    input  logic signed [31:0] w_value,
    output logic               th_valid,
    output logic [31:0]        theta,
    output wtps_pkg::side_t    side
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        o1_reg, o2_reg;
    logic [32:0] e_reg;
    logic [39:0] prod_reg;
    logic [29:0] res_reg;
    logic [31:0] th_reg;
    wtps_pkg::side_t side3_reg, side4_reg;

    logic signed [65:0] prod_next;
    logic [39:0]        turn_next;
    logic [31:0]        ang_next;
    logic [29:0]        resraw_next;
    logic               neg_next;
    logic [61:0]        thp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // phase product, negation and octant fold
    always_comb
    begin
        prod_next   = w_value * $signed({1'b0, e_reg});
        turn_next   = 40'd0 - prod_reg;
        ang_next    = turn_next[39:8] + 32'h2000_0000;
        resraw_next = ang_next[29:0];
        neg_next    = resraw_next < 30'h2000_0000;
        thp_next    = res_reg * wtps_pkg::TWO_PI_Q29;
    end

    always_ff @(posedge clk)
    begin
        e_reg             <= full ? 33'd0 : (33'h1_0000_0000 - {1'b0, root});
        o1_reg            <= outside;
        prod_reg          <= prod_next[39:0];
        o2_reg            <= o1_reg;
        res_reg           <= neg_next ? (30'h2000_0000 - resraw_next)
                                      : (resraw_next - 30'h2000_0000);
        side3_reg.quad    <= ang_next[31:30];
        side3_reg.neg     <= neg_next;
        side3_reg.outside <= o2_reg;
        th_reg            <= thp_next[60:29];
        side4_reg         <= side3_reg;
    end

    assign th_valid = v4_reg;
    assign theta    = th_reg;
    assign side     = side4_reg;

endmodule

// ===== hdl/wtps_trig.sv =====
// wtps_trig: Taylor sine and cosine, rounding, quadrant and special-case output mux
// depends on wtps_pkg
module wtps_trig (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  logic [31:0]          theta,
    input  wtps_pkg::side_t      side,
    input  logic                 w_zero,
    output logic                 result_valid,
    output wtps_pkg::out_word_t  result
);

    localparam int OB = wtps_pkg::OUT_BITS;

    logic            val_reg  [1:8];
    wtps_pkg::side_t side_reg [1:7];

    logic [31:0] a_th, a_th2;
    logic [31:0] b_th, b_th2, b_th3, b_th4;
    logic [31:0] c_th, c_th2, c_th3, c_th4, c_th5, c_th6, c_th8;
    logic [31:0] d_th, d_th2, d_th3, d_th4, d_th5, d_th6, d_th7, d_th8;
    logic [31:0] e_th, e_th2, e_x3, e_x4, e_x5, e_x6, e_x7, e_x8;
    logic [31:0] e_q3, e_q4, e_q5, e_q6, e_q7, e_q8;
    logic [31:0] f_th, f_th2, f_q3, f_q4, f_q5, f_q6, f_q7, f_q8;
    logic [32:0] sv_reg, cv_reg;
    wtps_pkg::out_word_t res_reg;

    logic [33:0]    sv_next, cv_next;
    logic [OB-1:0]  c_out, s_abs, s_out;
    logic [OB-1:0]  re_next, im_next;
    wtps_pkg::out_word_t res_next;

    // control: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 8; i++)
                val_reg[i] <= 1'b0;
        end
        else
        begin
            val_reg[1] <= valid;
            for (int i = 2; i <= 8; i++)
                val_reg[i] <= val_reg[i-1];
        end
    end

    // power ladder, one multiply level per stage
    always_ff @(posedge clk)
    begin
        side_reg[1] <= side;
        for (int i = 2; i <= 7; i++)
            side_reg[i] <= side_reg[i-1];

        a_th  <= theta;
        a_th2 <= wtps_pkg::mulq(theta, theta);

        b_th  <= a_th;
        b_th2 <= a_th2;
        b_th3 <= wtps_pkg::mulq(a_th2, a_th);
        b_th4 <= wtps_pkg::mulq(a_th2, a_th2);

        c_th  <= b_th;
        c_th2 <= b_th2;
        c_th3 <= b_th3;
        c_th4 <= b_th4;
        c_th5 <= wtps_pkg::mulq(b_th4, b_th);
        c_th6 <= wtps_pkg::mulq(b_th4, b_th2);
        c_th8 <= wtps_pkg::mulq(b_th4, b_th4);

        d_th  <= c_th;
        d_th2 <= c_th2;
        d_th3 <= c_th3;
        d_th4 <= c_th4;
        d_th5 <= c_th5;
        d_th6 <= c_th6;
        d_th7 <= wtps_pkg::mulq(c_th6, c_th);
        d_th8 <= c_th8;
    end

    // constant divisions: reciprocal estimate then one correction
    always_ff @(posedge clk)
    begin
        e_th  <= d_th;
        e_th2 <= d_th2;
        e_x3  <= d_th3;
        e_x4  <= d_th4;
        e_x5  <= d_th5;
        e_x6  <= d_th6;
        e_x7  <= d_th7;
        e_x8  <= d_th8;
        e_q3  <= wtps_pkg::div_est(d_th3, wtps_pkg::RECIP_6);
        e_q4  <= wtps_pkg::div_est(d_th4, wtps_pkg::RECIP_24);
        e_q5  <= wtps_pkg::div_est(d_th5, wtps_pkg::RECIP_120);
        e_q6  <= wtps_pkg::div_est(d_th6, wtps_pkg::RECIP_720);
        e_q7  <= wtps_pkg::div_est(d_th7, wtps_pkg::RECIP_5040);
        e_q8  <= wtps_pkg::div_est(d_th8, wtps_pkg::RECIP_40320);

        f_th  <= e_th;
        f_th2 <= e_th2;
        f_q3  <= wtps_pkg::div_fix(e_x3, e_q3, wtps_pkg::DIV_6);
        f_q4  <= wtps_pkg::div_fix(e_x4, e_q4, wtps_pkg::DIV_24);
        f_q5  <= wtps_pkg::div_fix(e_x5, e_q5, wtps_pkg::DIV_120);
        f_q6  <= wtps_pkg::div_fix(e_x6, e_q6, wtps_pkg::DIV_720);
        f_q7  <= wtps_pkg::div_fix(e_x7, e_q7, wtps_pkg::DIV_5040);
        f_q8  <= wtps_pkg::div_fix(e_x8, e_q8, wtps_pkg::DIV_40320);
    end

    // series sums
    always_comb
    begin
        sv_next = {2'b00, f_th} - {2'b00, f_q3} + {2'b00, f_q5} - {2'b00, f_q7};
        cv_next = 34'h1_0000_0000 - {3'b000, f_th2[31:1]} + {2'b00, f_q4}
                  - {2'b00, f_q6} + {2'b00, f_q8};
    end

    always_ff @(posedge clk)
    begin
        sv_reg <= sv_next[32:0];
        cv_reg <= cv_next[32:0];
    end

    // rounding, sign, quadrant and special cases
    always_comb
    begin
        c_out = wtps_pkg::to_out(cv_reg);
        s_abs = wtps_pkg::to_out(sv_reg);
        s_out = side_reg[7].neg ? (OB'(0) - s_abs) : s_abs;
        case (side_reg[7].quad)
            2'd0:
            begin
                re_next = c_out;
                im_next = s_out;
            end
            2'd1:
            begin
                re_next = OB'(0) - s_out;
                im_next = c_out;
            end
            2'd2:
            begin
                re_next = OB'(0) - c_out;
                im_next = OB'(0) - s_out;
            end
            default:
            begin
                re_next = s_out;
                im_next = OB'(0) - c_out;
            end
        endcase

        if (w_zero)
        begin
            res_next.real_part = $signed(OB'((1 << (OB - 1)) - 1));
            res_next.imag_part = '0;
            res_next.in_disc   = 1'b1;
        end
        else if (side_reg[7].outside)
        begin
            res_next.real_part = '0;
            res_next.imag_part = '0;
            res_next.in_disc   = 1'b0;
        end
        else
        begin
            res_next.real_part = $signed(re_next);
            res_next.imag_part = $signed(im_next);
            res_next.in_disc   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = val_reg[8];
    assign result       = res_reg;

endmodule

// ===== hdl/w_term_phase_screen.sv =====
// w_term_phase_screen: top level, configuration registers and pipeline chain
// depends on wtps_pkg, wtps_dircos, wtps_sqrt, wtps_phase, wtps_trig
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  pixel in  | start, busy, pixel                           | taken when start && !busy
//  result    | result_valid, result                         | one-cycle strobe, no stall
//  config    | psel penable pwrite paddr pwdata prdata pready | APB, pready tied high
//
// one word enters per clock; busy is never raised
// a word passes through the direction cosines, the one-bit-per-stage square root,
// the phase and the sine/cosine series
// reset clears valid bits and loads the register defaults; payload is not reset
// the result side cannot stall, so the pipeline only moves forward
module w_term_phase_screen (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  wtps_pkg::in_word_t  pixel,
    output logic                result_valid,
    output wtps_pkg::out_word_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    wtps_pkg::cfg_t cfg_reg;

    logic        t_valid, t_outside;
    logic [32:0] t_value;
    logic        r_valid, r_full, r_outside;
    logic [31:0] r_root;
    logic        th_valid;
    logic [31:0] theta;
    wtps_pkg::side_t side;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x  <= wtps_pkg::SIZE_W'(1);
            cfg_reg.size_y  <= wtps_pkg::SIZE_W'(1);
            cfg_reg.step_l  <= '0;
            cfg_reg.step_m  <= '0;
            cfg_reg.w_value <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                wtps_pkg::REG_SIZE_X:  cfg_reg.size_x  <= pwdata[wtps_pkg::SIZE_W-1:0];
                wtps_pkg::REG_SIZE_Y:  cfg_reg.size_y  <= pwdata[wtps_pkg::SIZE_W-1:0];
                wtps_pkg::REG_STEP_L:  cfg_reg.step_l  <= pwdata;
                wtps_pkg::REG_STEP_M:  cfg_reg.step_m  <= pwdata;
                wtps_pkg::REG_W_VALUE: cfg_reg.w_value <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    // configuration read
    always_comb
    begin
        case (paddr[4:2])
            wtps_pkg::REG_SIZE_X:  prdata = {19'd0, cfg_reg.size_x};
            wtps_pkg::REG_SIZE_Y:  prdata = {19'd0, cfg_reg.size_y};
            wtps_pkg::REG_STEP_L:  prdata = cfg_reg.step_l;
            wtps_pkg::REG_STEP_M:  prdata = cfg_reg.step_m;
            wtps_pkg::REG_W_VALUE: prdata = cfg_reg.w_value;
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // pipeline chain
    wtps_dircos u_dircos (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (start && !busy),
        .pixel   (pixel),
        .cfg     (cfg_reg),
        .t_valid (t_valid),
        .t_value (t_value),
        .outside (t_outside)
    );

    wtps_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (t_valid),
        .t_value   (t_value),
        .outside   (t_outside),
        .r_valid   (r_valid),
        .root      (r_root),
        .full      (r_full),
        .r_outside (r_outside)
    );

    wtps_phase u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (r_valid),
        .root     (r_root),
        .full     (r_full),
        .outside  (r_outside),
        .w_value  (cfg_reg.w_value),
        .th_valid (th_valid),
        .theta    (theta),
        .side     (side)
    );

    wtps_trig u_trig (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (th_valid),
        .theta        (theta),
        .side         (side),
        .w_zero       (cfg_reg.w_value == '0),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
